/* rtl/h2r_pkg.sv */
// Shared types, constants and helper functions of the HSL to RGB converter.
package h2r_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int IN_FRAC           = 16;
    localparam logic [16:0] IN_ONE   = 17'd65536;

    localparam int HUE_CIRCLE        = 360;
    localparam int RAMP_SPAN         = 60;
    localparam int HUE_RAMP_UP_END   = 60;
    localparam int HUE_PLATEAU_END   = 180;
    localparam int HUE_RAMP_DOWN_END = 240;
    localparam int HUE_RED_OFFSET    = 120;
    localparam int HUE_BLUE_OFFSET   = 240;

    // Reciprocal of 360 scaled by 2^24, rounded up; exact for every 16-bit hue.
    localparam logic [15:0] HUE_RECIP       = 16'd46604;
    localparam int          HUE_RECIP_SHIFT = 24;

    localparam int NUM_CH = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [15:0] hue_degrees;
        logic [16:0] saturation;
        logic [16:0] lightness;
    } hsl_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    function automatic logic [8:0] hue_shift(input logic [8:0] d, input logic [8:0] offset);
        logic [9:0] sum;
        sum = {1'b0, d} + {1'b0, offset};
        if (sum >= 10'(HUE_CIRCLE))
        begin
            sum = sum - 10'(HUE_CIRCLE);
        end
        return sum[8:0];
    endfunction

    // Weight of the ramp in sixtieths: 0 selects p, 60 selects q.
    function automatic logic [5:0] ramp_weight(input logic [8:0] d);
        logic [8:0] w;
        if (d < 9'(HUE_RAMP_UP_END))
        begin
            w = d;
        end
        else if (d < 9'(HUE_PLATEAU_END))
        begin
            w = 9'(RAMP_SPAN);
        end
        else if (d < 9'(HUE_RAMP_DOWN_END))
        begin
            w = 9'(HUE_RAMP_DOWN_END) - d;
        end
        else
        begin
            w = 9'd0;
        end
        return w[5:0];
    endfunction

endpackage

/* rtl/h2r_prep.sv */
// Front pipeline stages: input scaling, hue reduction, the p and q levels and the ramp weights.
module h2r_prep
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  hsl_t                        hsl,
    output logic                        out_valid,
    output logic [FRAC_BITS:0]          p_level,
    output logic [FRAC_BITS:0]          diff,
    output logic [NUM_CH-1:0][5:0]      weight
);

    localparam int FW = FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 3;
    localparam int MW = 2 * FRAC_BITS + 3;
    localparam logic [FW-1:0] ONE  = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] HALF = FW'(1) << (FRAC_BITS - 1);

    logic [16:0]   s_sat;
    logic [16:0]   l_sat;
    logic [FW-1:0] s_next;
    logic [FW-1:0] l_next;
    logic [31:0]   hue_prod;
    logic [7:0]    quot_next;

    logic          valid_a_reg;
    logic [15:0]   hue_a_reg;
    logic [7:0]    quot_a_reg;
    logic [FW-1:0] s_a_reg;
    logic [FW-1:0] l_a_reg;

    logic          low_next;
    logic [FW:0]   opnd;
    logic [MW-1:0] product;
    logic [15:0]   rem_full;

    logic          valid_b_reg;
    logic [PW-1:0] prod_b_reg;
    logic [8:0]    rem_b_reg;
    logic          low_b_reg;
    logic [FW-1:0] s_b_reg;
    logic [FW-1:0] l_b_reg;

    logic [PW-1:0] q_full;

    logic          valid_c_reg;
    logic [FW-1:0] q_c_reg;
    logic [FW-1:0] l_c_reg;
    logic [8:0]    rem_c_reg;

    logic [FW:0]   p_wide;
    logic [FW-1:0] q_minus_l;
    logic [NUM_CH-1:0][5:0] weight_next;

    logic          valid_d_reg;
    logic [FW-1:0] p_d_reg;
    logic [FW-1:0] diff_d_reg;
    logic [NUM_CH-1:0][5:0] weight_d_reg;

    assign s_sat = (hsl.saturation > IN_ONE) ? IN_ONE : hsl.saturation;
    assign l_sat = (hsl.lightness > IN_ONE) ? IN_ONE : hsl.lightness;

    if (FRAC_BITS >= IN_FRAC)
    begin : g_scale_up
        assign s_next = FW'(s_sat) << (FRAC_BITS - IN_FRAC);
        assign l_next = FW'(l_sat) << (FRAC_BITS - IN_FRAC);
    end
    else
    begin : g_scale_down
        assign s_next = FW'(s_sat >> (IN_FRAC - FRAC_BITS));
        assign l_next = FW'(l_sat >> (IN_FRAC - FRAC_BITS));
    end

    assign hue_prod  = hsl.hue_degrees * HUE_RECIP;
    assign quot_next = hue_prod[HUE_RECIP_SHIFT+7:HUE_RECIP_SHIFT];

    assign low_next = (l_a_reg < HALF);
    assign opnd     = low_next ? ((FW + 1)'(ONE) + (FW + 1)'(s_a_reg)) : (FW + 1)'(s_a_reg);
    assign product  = MW'(l_a_reg) * MW'(opnd);
    assign rem_full = hue_a_reg - 16'({8'd0, quot_a_reg} * 16'(HUE_CIRCLE));

    assign q_full = low_b_reg ? prod_b_reg
                              : (PW'(l_b_reg) + PW'(s_b_reg) - prod_b_reg);

    assign p_wide    = {l_c_reg, 1'b0} - {1'b0, q_c_reg};
    assign q_minus_l = q_c_reg - l_c_reg;

    always_comb
    begin
        weight_next[CH_RED]   = ramp_weight(hue_shift(rem_c_reg, 9'(HUE_RED_OFFSET)));
        weight_next[CH_GREEN] = ramp_weight(rem_c_reg);
        weight_next[CH_BLUE]  = ramp_weight(hue_shift(rem_c_reg, 9'(HUE_BLUE_OFFSET)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_a_reg    <= hsl.hue_degrees;
        quot_a_reg   <= quot_next;
        s_a_reg      <= s_next;
        l_a_reg      <= l_next;

        prod_b_reg   <= product[MW-1:FRAC_BITS];
        rem_b_reg    <= rem_full[8:0];
        low_b_reg    <= low_next;
        s_b_reg      <= s_a_reg;
        l_b_reg      <= l_a_reg;

        q_c_reg      <= q_full[FW-1:0];
        l_c_reg      <= l_b_reg;
        rem_c_reg    <= rem_b_reg;

        p_d_reg      <= p_wide[FW-1:0];
        diff_d_reg   <= {q_minus_l[FW-2:0], 1'b0};
        weight_d_reg <= weight_next;
    end

    assign out_valid = valid_d_reg;
    assign p_level   = p_d_reg;
    assign diff      = diff_d_reg;
    assign weight    = weight_d_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg |-> (q_c_reg >= l_c_reg) && (q_c_reg <= ONE))
        else $error("q level outside the range from lightness to one");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_d_reg |-> (weight_d_reg[CH_RED] <= 6'(RAMP_SPAN))
                     && (weight_d_reg[CH_GREEN] <= 6'(RAMP_SPAN))
                     && (weight_d_reg[CH_BLUE] <= 6'(RAMP_SPAN)))
        else $error("ramp weight above one full span");

endmodule

/* rtl/h2r_ramp.sv */
// Back pipeline stages: per-channel hue ramp, division by sixty and byte scaling.
module h2r_ramp
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [FRAC_BITS:0]          p_level,
    input  logic [FRAC_BITS:0]          diff,
    input  logic [NUM_CH-1:0][5:0]      weight,
    output logic                        out_valid,
    output logic [NUM_CH-1:0][7:0]      channel
);

    localparam int FW          = FRAC_BITS + 1;
    localparam int XW          = FRAC_BITS + 6;
    localparam int RW          = FRAC_BITS + 7;
    localparam int RECIP_SHIFT = FRAC_BITS + 12;
    localparam int YW          = 2 * FRAC_BITS + 13;
    localparam int SW          = FRAC_BITS + 9;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << RECIP_SHIFT) + 64'(RAMP_SPAN - 1)) / 64'(RAMP_SPAN);
    localparam logic [RW-1:0] RECIP = RECIP_WIDE[RW-1:0];

    logic [NUM_CH-1:0][XW-1:0] x_next;
    logic [NUM_CH-1:0][YW-1:0] y_next;
    logic [NUM_CH-1:0][SW-1:0] scaled_next;

    logic                      valid_e_reg;
    logic [FW-1:0]             p_e_reg;
    logic [NUM_CH-1:0][XW-1:0] x_reg;

    logic                      valid_f_reg;
    logic [FW-1:0]             p_f_reg;
    logic [NUM_CH-1:0][FW-1:0] quot_reg;

    logic                      valid_g_reg;
    logic [NUM_CH-1:0][FW-1:0] level_reg;

    logic                      valid_h_reg;
    logic [NUM_CH-1:0][7:0]    chan_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            x_next[c]      = XW'(XW'(diff) * XW'(weight[c]));
            y_next[c]      = YW'(x_reg[c]) * YW'(RECIP);
            scaled_next[c] = {level_reg[c], 8'd0} - SW'(level_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
            valid_h_reg <= 1'b0;
        end
        else
        begin
            valid_e_reg <= in_valid;
            valid_f_reg <= valid_e_reg;
            valid_g_reg <= valid_f_reg;
            valid_h_reg <= valid_g_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_e_reg <= p_level;
        p_f_reg <= p_e_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            x_reg[c]     <= x_next[c];
            quot_reg[c]  <= y_next[c][YW-1:RECIP_SHIFT];
            level_reg[c] <= p_f_reg + quot_reg[c];
            chan_reg[c]  <= scaled_next[c][FRAC_BITS+7:FRAC_BITS];
        end
    end

    assign out_valid = valid_h_reg;
    assign channel   = chan_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_g_reg |-> (level_reg[CH_RED] <= ONE) && (level_reg[CH_GREEN] <= ONE)
                     && (level_reg[CH_BLUE] <= ONE))
        else $error("channel level above one");

endmodule

/* rtl/hsl_to_rgb_converter.sv */
// Top level of the pipelined HSL to RGB colour converter.
//
// One colour enters on hsl when start is high and busy is low; busy is held
// low, so a new colour may be transferred in every clock cycle.
// The hue is in whole degrees and is reduced modulo 360 inside; saturation
// and lightness are unsigned fixed point where 65536 stands for 1.0, and
// larger values are treated as 1.0.
// Each result appears on rgba for exactly one cycle with done high, once its
// colour has passed through all eight register stages, and results leave in
// the order the colours came in. Alpha is always 255.
// Throughput is one colour per cycle: eight register stages of comparable
// depth, with a valid bit travelling beside the data. The two widest steps
// are the 16-bit hue reduction by a reciprocal multiply and the division of
// the ramp product by sixty, also a reciprocal multiply.
// The receiver cannot hold results off, so the pipeline never stalls.
// Reset clears every valid bit, so no result is produced from a colour that
// was in flight when reset arrived.
module hsl_to_rgb_converter
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  hsl_t  hsl,
    output logic  done,
    output rgba_t rgba
);

    logic                   accept;
    logic                   prep_valid;
    logic [FRAC_BITS:0]     p_level;
    logic [FRAC_BITS:0]     diff;
    logic [NUM_CH-1:0][5:0] weight;
    logic [NUM_CH-1:0][7:0] channel;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    h2r_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .hsl       (hsl),
        .out_valid (prep_valid),
        .p_level   (p_level),
        .diff      (diff),
        .weight    (weight)
    );

    h2r_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .p_level   (p_level),
        .diff      (diff),
        .weight    (weight),
        .out_valid (done),
        .channel   (channel)
    );

    assign rgba.red   = channel[CH_RED];
    assign rgba.green = channel[CH_GREEN];
    assign rgba.blue  = channel[CH_BLUE];
    assign rgba.alpha = ALPHA_OPAQUE;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##8 done)
        else $error("transferred colour gave no result after eight cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 8))
        else $error("result without a colour transferred eight cycles earlier");

endmodule

/* verif/tb_hsl_to_rgb_converter.sv */
// Self-checking testbench of the HSL to RGB colour converter: directed corners, then random colours.
module tb_hsl_to_rgb_converter;
    import h2r_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC       = DEFAULT_FRAC_BITS;
    localparam int DRAIN_WAIT = 12;
    localparam int MAX_LINES  = 20;

    typedef struct {
        hsl_t  colour;
        rgba_t rgba;
    } colour_check_t;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    hsl_t  hsl   = '0;
    logic  busy;
    logic  done;
    rgba_t rgba;

    colour_check_t pending_rgba[$];
    colour_check_t oldest;
    int            error_count    = 0;
    int            colours_sent   = 0;
    int            results_seen   = 0;
    int            drain_pauses   = 0;

    hsl_to_rgb_converter DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .hsl   (hsl),
        .done  (done),
        .rgba  (rgba)
    );

    always #4 clk = ~clk;

    function automatic longint level_to_fix(input logic [16:0] v);
        longint x;
        x = (v > IN_ONE) ? longint'(IN_ONE) : longint'(v);
        if (FRAC >= IN_FRAC)
        begin
            return x <<< (FRAC - IN_FRAC);
        end
        return x >>> (IN_FRAC - FRAC);
    endfunction

    function automatic logic [7:0] channel_byte(input longint p, input longint q,
                                                input int unsigned d);
        longint level;
        if (d < 60)
        begin
            level = p + ((q - p) * longint'(d)) / 60;
        end
        else if (d < 180)
        begin
            level = q;
        end
        else if (d < 240)
        begin
            level = p + ((q - p) * longint'(240 - d)) / 60;
        end
        else
        begin
            level = p;
        end
        if (level < 0)
        begin
            level = 0;
        end
        if (level > (longint'(1) <<< FRAC))
        begin
            level = longint'(1) <<< FRAC;
        end
        return 8'((level * 255) >>> FRAC);
    endfunction

    function automatic rgba_t hsl_to_rgba(input hsl_t c);
        rgba_t       res;
        int unsigned hue;
        longint      s;
        longint      l;
        longint      q;
        longint      p;
        hue = int'(c.hue_degrees) % HUE_CIRCLE;
        s = level_to_fix(c.saturation);
        l = level_to_fix(c.lightness);
        res.alpha = ALPHA_OPAQUE;
        if (s == 0)
        begin
            res.red   = channel_byte(l, l, 120);
            res.green = res.red;
            res.blue  = res.red;
        end
        else
        begin
            if (l < (longint'(1) <<< (FRAC - 1)))
            begin
                q = (l * ((longint'(1) <<< FRAC) + s)) >>> FRAC;
            end
            else
            begin
                q = l + s - ((l * s) >>> FRAC);
            end
            p = 2 * l - q;
            res.red   = channel_byte(p, q, (hue + HUE_RED_OFFSET) % HUE_CIRCLE);
            res.green = channel_byte(p, q, hue);
            res.blue  = channel_byte(p, q, (hue + HUE_BLUE_OFFSET) % HUE_CIRCLE);
        end
        return res;
    endfunction

    function automatic logic [16:0] random_level();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return IN_ONE;
            2: return 17'($urandom());
            3: return 17'($urandom_range(32768 - 64, 32768 + 64));
            4: return 17'($urandom_range(0, 255));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic hsl_t random_colour();
        hsl_t c;
        if ($urandom_range(0, 3) == 0)
        begin
            c.hue_degrees = 16'($urandom());
        end
        else
        begin
            c.hue_degrees = 16'($urandom_range(0, HUE_CIRCLE - 1));
        end
        c.saturation = random_level();
        c.lightness  = random_level();
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_LINES)
        begin
            $display("%t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_channel(input string name, input logic [7:0] got,
                                 input logic [7:0] want, input hsl_t c);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d want %0d (hue %0d sat %0d light %0d)",
                                      name, got, want, c.hue_degrees, c.saturation,
                                      c.lightness));
        end
    endtask

    // Called just after a rising edge; returns just after the transfer or any idle gap behind it.
    task automatic send_colour(input hsl_t c, input int idle_pct);
        colour_check_t entry;
        logic          was_busy;
        start <= 1'b1;
        hsl   <= c;
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
        entry.colour = c;
        entry.rgba   = hsl_to_rgba(c);
        pending_rgba.push_back(entry);
        colours_sent++;
        while ($urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_rgba.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        hsl_t c;
        int   k;
        logic [15:0] hues[14] = '{16'd0, 16'd59, 16'd60, 16'd119, 16'd120, 16'd179, 16'd180,
                                  16'd239, 16'd240, 16'd299, 16'd300, 16'd359, 16'd360,
                                  16'd65535};
        for (k = 0; k < 14; k++)
        begin
            c.hue_degrees = hues[k];
            c.saturation  = IN_ONE;
            c.lightness   = 17'd32768;
            send_colour(c, 0);
        end
        c = '{16'd200, 17'd0, 17'd0};         send_colour(c, 0);
        c = '{16'd200, 17'd0, 17'd40000};     send_colour(c, 0);
        c = '{16'd200, 17'd0, IN_ONE};        send_colour(c, 0);
        c = '{16'd30, 17'h1FFFF, 17'd20000};  send_colour(c, 0);
        c = '{16'd30, 17'd30000, 17'h1FFFF};  send_colour(c, 0);
        c = '{16'd90, 17'd1, 17'd32767};      send_colour(c, 0);
        c = '{16'd90, 17'd65535, 17'd32767};  send_colour(c, 0);
        c = '{16'd210, 17'd50000, 17'd65535}; send_colour(c, 0);
        c = '{16'd45, 17'd65536, 17'd1};      send_colour(c, 0);
        c = '{16'hFFFF, 17'h1FFFF, 17'h1FFFF}; send_colour(c, 0);
        c = '{16'h0000, 17'h00000, 17'h00000}; send_colour(c, 0);
    endtask

    task automatic test_random(input int count, input int idle_pct);
        repeat (count)
        begin
            send_colour(random_colour(), idle_pct);
        end
    endtask

    task automatic test_drain_pauses(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_colour(random_colour(), 0);
            if ((n == count / 2) || ($urandom_range(0, 49) == 0))
            begin
                wait_for_drain();
                drain_pauses++;
                @(posedge clk);
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rgba.size() == 0)
            begin
                report_mismatch($sformatf("result with no colour waiting: %h", rgba));
            end
            else
            begin
                oldest = pending_rgba.pop_front();
                results_seen++;
                check_channel("red", rgba.red, oldest.rgba.red, oldest.colour);
                check_channel("green", rgba.green, oldest.rgba.green, oldest.colour);
                check_channel("blue", rgba.blue, oldest.rgba.blue, oldest.colour);
                check_channel("alpha", rgba.alpha, oldest.rgba.alpha, oldest.colour);
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(500, 0);
        test_random(500, 79);
        test_random(500, 9);
        test_drain_pauses(400);
        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Run covered %0d colour transfers and %0d checked results,",
                 colours_sent, results_seen);
        $display("with sender gaps of 0, 79 and 9 percent and %0d full drains.",
                 drain_pauses);
        if (error_count == 0)
        begin
            $display("tb_hsl_to_rgb_converter: clean");
        end
        else
        begin
            $display("tb_hsl_to_rgb_converter: errors");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", pending_rgba.size());
        $display("tb_hsl_to_rgb_converter: errors");
        $finish;
    end

endmodule
